// ===== rtl/u8s_pkg.sv =====
// ---------------------------------------------------------------------------
// u8s_pkg
// shared types and constants of the strict utf-8 cursor step block
// ---------------------------------------------------------------------------
package u8s_pkg;

    localparam int BYTE_W  = 8;
    localparam int AVAIL_W = 3;
    localparam int STEP_W  = 3;
    localparam int CP_W    = 21;

    // direction of the step
    typedef enum logic
    {
        OP_FWD = 1'b0,
        OP_BWD = 1'b1
    } opcode_e;

    // one window beat as held in the input stage
    typedef struct packed
    {
        opcode_e               opcode;
        logic [BYTE_W-1:0]     byte_a;
        logic [BYTE_W-1:0]     byte_b;
        logic [BYTE_W-1:0]     byte_c;
        logic [BYTE_W-1:0]     byte_d;
        logic [AVAIL_W-1:0]    avail;
    } in_item_t;

    // one result beat
    typedef struct packed
    {
        logic [STEP_W-1:0]     step;
        logic                  valid_res;
        logic [CP_W-1:0]       codepoint;
        logic                  dangerous;
    } out_item_t;

endpackage

// ===== rtl/u8s_if.sv =====
// ---------------------------------------------------------------------------
// u8s_if
// valid/ready channels for window beats and result beats
// ---------------------------------------------------------------------------
interface u8s_in_if;
    import u8s_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [BYTE_W-1:0]     byte_a;
    logic [BYTE_W-1:0]     byte_b;
    logic [BYTE_W-1:0]     byte_c;
    logic [BYTE_W-1:0]     byte_d;
    logic [AVAIL_W-1:0]    avail;

    modport source (output valid, opcode, byte_a, byte_b, byte_c, byte_d, avail,
                    input ready);
    modport sink   (input valid, opcode, byte_a, byte_b, byte_c, byte_d, avail,
                    output ready);
endinterface

interface u8s_out_if;
    import u8s_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STEP_W-1:0]     step;
    logic                  valid_res;
    logic [CP_W-1:0]       codepoint;
    logic                  dangerous;

    modport source (output valid, step, valid_res, codepoint, dangerous,
                    input ready);
    modport sink   (input valid, step, valid_res, codepoint, dangerous,
                    output ready);
endinterface

// ===== rtl/u8s_decode.sv =====
// ---------------------------------------------------------------------------
// u8s_decode
// combinational strict utf-8 step, decode and dangerous-codepoint check
// ---------------------------------------------------------------------------
module u8s_decode
(
    input  u8s_pkg::in_item_t   item,
    output u8s_pkg::out_item_t  res
);
    import u8s_pkg::*;

    typedef struct packed
    {
        logic            ok;
        logic [CP_W-1:0] cp;
    } dec_t;

    // sequence length announced by a leader, 1 for ascii and non-leaders
    function automatic logic [STEP_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [STEP_W-1:0] n;
        priority if (b[7] == 1'b0)       n = 3'd1;
        else if (b[7:5] == 3'b110)        n = 3'd2;
        else if (b[7:4] == 4'b1110)       n = 3'd3;
        else if (b[7:3] == 5'b11110)      n = 3'd4;
        else                              n = 3'd1;
        return n;
    endfunction

    function automatic logic is_cont(input logic [BYTE_W-1:0] b);
        return b[7:6] == 2'b10;
    endfunction

    // strict decode of n bytes in buffer order
    function automatic dec_t strict_decode(input logic [STEP_W-1:0] n,
                                           input logic [BYTE_W-1:0] b0,
                                           input logic [BYTE_W-1:0] b1,
                                           input logic [BYTE_W-1:0] b2,
                                           input logic [BYTE_W-1:0] b3);
        dec_t d;
        d.ok = 1'b0;
        d.cp = '0;
        unique case (n)
            3'd1:
            begin
                d.ok = (b0[7] == 1'b0);
                d.cp = {14'd0, b0[6:0]};
            end
            3'd2:
            begin
                d.cp = {10'd0, b0[4:0], b1[5:0]};
                d.ok = is_cont(b1) && (d.cp >= 21'h80);
            end
            3'd3:
            begin
                d.cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                d.ok = is_cont(b1) && is_cont(b2) && (d.cp >= 21'h800)
                       && !((d.cp >= 21'hD800) && (d.cp <= 21'hDFFF));
            end
            3'd4:
            begin
                d.cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
                d.ok = is_cont(b1) && is_cont(b2) && is_cont(b3)
                       && (d.cp >= 21'h10000) && (d.cp <= 21'h10FFFF);
            end
            default:
            begin
                d.ok = 1'b0;
            end
        endcase
        return d;
    endfunction

    // invisible, bidi control and tag codepoints
    function automatic logic is_dangerous(input logic [CP_W-1:0] c);
        return (c == 21'h00AD) || (c == 21'h034F) || (c == 21'h061C)
            || (c == 21'h115F) || (c == 21'h1160) || (c == 21'h180E)
            || ((c >= 21'h200B) && (c <= 21'h200F))
            || ((c >= 21'h202A) && (c <= 21'h202E))
            || (c == 21'h2028) || (c == 21'h2029)
            || ((c >= 21'h2060) && (c <= 21'h206F))
            || (c == 21'h3164) || (c == 21'hFEFF) || (c == 21'hFFA0)
            || ((c >= 21'hFFF9) && (c <= 21'hFFFB))
            || ((c >= 21'hE0000) && (c <= 21'hE007F));
    endfunction

    logic [STEP_W-1:0] fwd_n;
    logic [STEP_W-1:0] bwd_n;
    dec_t              fwd_dec;
    dec_t              bwd_dec;
    logic              fwd_ok;
    logic              bwd_ok;
    logic              run0;
    logic              run1;
    logic              run2;
    logic [BYTE_W-1:0] seq0;
    logic [BYTE_W-1:0] seq1;
    logic [BYTE_W-1:0] seq2;
    logic [BYTE_W-1:0] seq3;
    logic              ok;
    logic [STEP_W-1:0] n_sel;

    // forward: leader at the cursor
    always_comb
    begin
        fwd_n   = lead_len(item.byte_a);
        fwd_dec = strict_decode(fwd_n, item.byte_a, item.byte_b, item.byte_c, item.byte_d);
        fwd_ok  = (fwd_n <= item.avail) && fwd_dec.ok;
    end

    // backward: walk over continuation bytes, then reorder into buffer order
    always_comb
    begin
        run0 = is_cont(item.byte_a) && (item.avail > 3'd1);
        run1 = run0 && is_cont(item.byte_b) && (item.avail > 3'd2);
        run2 = run1 && is_cont(item.byte_c) && (item.avail > 3'd3);
        priority if (run2)
        begin
            bwd_n = 3'd4;
            seq0  = item.byte_d;
            seq1  = item.byte_c;
            seq2  = item.byte_b;
            seq3  = item.byte_a;
        end
        else if (run1)
        begin
            bwd_n = 3'd3;
            seq0  = item.byte_c;
            seq1  = item.byte_b;
            seq2  = item.byte_a;
            seq3  = '0;
        end
        else if (run0)
        begin
            bwd_n = 3'd2;
            seq0  = item.byte_b;
            seq1  = item.byte_a;
            seq2  = '0;
            seq3  = '0;
        end
        else
        begin
            bwd_n = 3'd1;
            seq0  = item.byte_a;
            seq1  = '0;
            seq2  = '0;
            seq3  = '0;
        end
        bwd_dec = strict_decode(bwd_n, seq0, seq1, seq2, seq3);
        bwd_ok  = bwd_dec.ok && ((bwd_n == 3'd1) || (lead_len(seq0) == bwd_n));
    end

    // result selection
    always_comb
    begin
        ok    = (item.opcode == OP_BWD) ? bwd_ok : fwd_ok;
        n_sel = (item.opcode == OP_BWD) ? bwd_n : fwd_n;
        if (item.avail == '0)
        begin
            res = '0;
        end
        else
        begin
            res.step      = ok ? n_sel : 3'd1;
            res.valid_res = ok;
            res.codepoint = ok ? ((item.opcode == OP_BWD) ? bwd_dec.cp : fwd_dec.cp) : '0;
            res.dangerous = ok && is_dangerous(res.codepoint);
        end
    end

endmodule

// ===== rtl/utf8_strict_step_top.sv =====
// ---------------------------------------------------------------------------
// utf8_strict_step_top
// strict utf-8 cursor step over a four-byte window, while rsp is not stalled one window per cycle
// ---------------------------------------------------------------------------
//  channel | dir | payload                                      | handshake
//  cmd     | in  | opcode, byte_a..byte_d, avail                 | valid/ready
//  rsp     | out | step, valid_res, codepoint, dangerous flag    | valid/ready
//
//  a cmd beat passes an input register, then the decode logic into the result
//  register; one beat per cycle sustained while rsp is not stalled
//  reset clears both stage valid bits, payload registers are not reset
//  a stall on rsp holds the result register; the input stage still takes one
//  more beat, and cmd.ready drops only when both stages are full and stalled
// ---------------------------------------------------------------------------
module utf8_strict_step_top
(
    input  logic      clk,
    input  logic      rst_n,
    u8s_in_if.sink    cmd,
    u8s_out_if.source rsp
);
    import u8s_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    in_item_t  s1_item_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    out_item_t dec_res;
    logic      out_free;
    logic      s1_adv;
    logic      cmd_fire;

    // decode of the held window
    u8s_decode u_decode
    (
        .item (s1_item_reg),
        .res  (dec_res)
    );

    // stage flow control
    always_comb
    begin
        out_free  = !out_valid_reg || rsp.ready;
        s1_adv    = s1_valid_reg && out_free;
        cmd.ready = !s1_valid_reg || out_free;
        cmd_fire  = cmd.valid && cmd.ready;

        s1_valid_next  = cmd_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

        s1_item_next.opcode = opcode_e'(cmd.opcode);
        s1_item_next.byte_a = cmd.byte_a;
        s1_item_next.byte_b = cmd.byte_b;
        s1_item_next.byte_c = cmd.byte_c;
        s1_item_next.byte_d = cmd.byte_d;
        s1_item_next.avail  = cmd.avail;
        out_item_next       = dec_res;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_item_reg <= s1_item_next;
        end
        if (s1_adv)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // result port
    assign rsp.valid     = out_valid_reg;
    assign rsp.step      = out_item_reg.step;
    assign rsp.valid_res = out_item_reg.valid_res;
    assign rsp.codepoint = out_item_reg.codepoint;
    assign rsp.dangerous = out_item_reg.dangerous;

    // a held window always moves into the result register on the next edge
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("decoded window lost between stages");

    // rejected or empty results carry no codepoint and no danger flag
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.valid_res) |-> (rsp.codepoint == '0 && !rsp.dangerous))
        else $error("rejected result carries decoded fields");

    // a valid sequence always moves the cursor by one to four bytes
    a_valid_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.valid_res) |-> (rsp.step != '0 && rsp.step <= 3'd4))
        else $error("valid result with bad step");

    // input is held off only when both stages are full
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

endmodule
